// File: rtl/base64_vlq_mapping_decoder_unit_defines.svh
// Assertion macros shared by the decoder RTL.
`ifndef BASE64_VLQ_MAPPING_DECODER_UNIT_DEFINES_SVH
`define BASE64_VLQ_MAPPING_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define B64VLQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define B64VLQ_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/b64vlq_pkg.sv
package b64vlq_pkg;

  // Default accumulator width
  localparam int unsigned ACC_WIDTH_DEF = 32;

  // Output value field width
  localparam int unsigned OUT_WIDTH = 32;

  // Mapping string characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_DIG_0 = 8'h30;
  localparam logic [7:0] CH_DIG_9 = 8'h39;

  // Base64 digit values at the range starts
  localparam logic [5:0] B64_LO_BASE  = 6'd26;
  localparam logic [5:0] B64_DIG_BASE = 6'd52;
  localparam logic [5:0] B64_PLUS     = 6'd62;
  localparam logic [5:0] B64_SLASH    = 6'd63;

  // VLQ framing
  localparam int unsigned VLQ_GROUP_BITS = 5;
  localparam logic [5:0]  VLQ_SHIFT_STEP = 6'd5;
  localparam logic [5:0]  VLQ_SHIFT_MAX  = 6'd60;
  localparam logic [2:0]  NUM_FIELDS     = 3'd5;

  typedef enum logic [2:0] {
    CLS_COMMA,
    CLS_SEMI,
    CLS_QUOTE,
    CLS_DIGIT,
    CLS_BAD
  } ch_class_e;

  // One result item
  typedef struct packed {
    logic [OUT_WIDTH-1:0] gen_line;
    logic [OUT_WIDTH-1:0] gen_column;
    logic [OUT_WIDTH-1:0] src_idx;
    logic [OUT_WIDTH-1:0] orig_line;
    logic [OUT_WIDTH-1:0] orig_col;
    logic [OUT_WIDTH-1:0] name_idx;
    logic                 has_segment;
    logic                 error;
    logic                 done_res;
  } res_t;

  function automatic logic is_b64(input logic [7:0] ch);
    return ((ch >= CH_UP_A) && (ch <= CH_UP_Z)) ||
           ((ch >= CH_LO_A) && (ch <= CH_LO_Z)) ||
           ((ch >= CH_DIG_0) && (ch <= CH_DIG_9)) ||
           (ch == CH_PLUS) || (ch == CH_SLASH);
  endfunction

  function automatic ch_class_e classify(input logic [7:0] ch);
    ch_class_e cls;
    if (ch == CH_COMMA)     cls = CLS_COMMA;
    else if (ch == CH_SEMI) cls = CLS_SEMI;
    else if (ch == CH_QUOTE) cls = CLS_QUOTE;
    else if (is_b64(ch))    cls = CLS_DIGIT;
    else                    cls = CLS_BAD;
    return cls;
  endfunction

  // Base64 digit value; only meaningful for digit characters
  function automatic logic [5:0] b64_value(input logic [7:0] ch);
    logic [7:0] diff;
    logic [5:0] val;
    diff = '0;
    val  = '0;
    if ((ch >= CH_UP_A) && (ch <= CH_UP_Z)) begin
      diff = ch - CH_UP_A;
      val  = diff[5:0];
    end else if ((ch >= CH_LO_A) && (ch <= CH_LO_Z)) begin
      diff = ch - CH_LO_A;
      val  = diff[5:0] + B64_LO_BASE;
    end else if ((ch >= CH_DIG_0) && (ch <= CH_DIG_9)) begin
      diff = ch - CH_DIG_0;
      val  = diff[5:0] + B64_DIG_BASE;
    end else if (ch == CH_PLUS) begin
      val = B64_PLUS;
    end else if (ch == CH_SLASH) begin
      val = B64_SLASH;
    end
    return val;
  endfunction

endpackage

// File: rtl/b64vlq_out_skid.sv
module b64vlq_out_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  b64vlq_pkg::res_t  data_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output b64vlq_pkg::res_t  data_o
);

  logic             out_vld_q, out_vld_d;
  logic             skid_vld_q, skid_vld_d;
  b64vlq_pkg::res_t out_q, out_d;
  b64vlq_pkg::res_t skid_q, skid_d;
  logic             pop;

  assign pop         = out_vld_q && out_ready_i;
  assign ready_o     = !skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign data_o      = out_q;

  // Two-entry output buffer: skid entry always drains first
  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (pop) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end else if (push_i) begin
        out_d = data_i;
      end else begin
        out_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_vld_q) begin
        out_d     = data_i;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = data_i;
        skid_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

// File: rtl/base64_vlq_mapping_decoder_unit.sv
// Streaming decoder for the mappings string of a v3 source map.
// Input channel: one character per item (ch_i), with first_i set on the
// first character of a new string to clear all running state. Handshake
// is in_valid_i / in_ready_o. Output channel: out_valid_o / out_ready_i
// with one segment record per item: generated line and column, source
// index, original line and column, name index, plus has_segment, error
// and done_res flags.
// A comma or semicolon yields one record; the closing quote yields the
// final record (done_res set); an invalid character or a sixth field in a
// segment yields an error record and halts until the next first_i.
// Other characters yield no record.
// Throughput: one character per cycle while in_ready_o is high. Each
// character takes a single pass through the digit decode, the VLQ group
// merge and one accumulator add/subtract before the state registers. A
// record is registered in the output buffer before it is on the output.
// The output is a two-entry buffer; in_ready_o falls only when both
// entries are full, so a stalled receiver halts the input after two
// pending records.
// Reset clears the accumulators (original line to one), the VLQ state,
// the halt flag and the output buffer.
`include "base64_vlq_mapping_decoder_unit_defines.svh"

module base64_vlq_mapping_decoder_unit #(
  parameter int unsigned ACC_WIDTH = b64vlq_pkg::ACC_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  input  logic        first_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] gen_line_o,
  output logic [31:0] gen_column_o,
  output logic [31:0] src_idx_o,
  output logic [31:0] orig_line_o,
  output logic [31:0] orig_col_o,
  output logic [31:0] name_idx_o,
  output logic        has_segment_o,
  output logic        error_o,
  output logic        done_res_o
);

  localparam logic [ACC_WIDTH-1:0] ACC_ONE = ACC_WIDTH'(1);

  // Running state
  logic [ACC_WIDTH-1:0] partial_q, partial_d;
  logic [5:0]           shift_q, shift_d;
  logic [2:0]           fcnt_q, fcnt_d;
  logic [ACC_WIDTH-1:0] line_q, line_d;
  logic [ACC_WIDTH-1:0] acc_q [5];
  logic [ACC_WIDTH-1:0] acc_d [5];
  logic                 seg_begun_q, seg_begun_d;
  logic                 halted_q, halted_d;

  // State after an optional clear by first_i
  logic [ACC_WIDTH-1:0] cur_partial;
  logic [5:0]           cur_shift;
  logic [2:0]           cur_fcnt;
  logic [ACC_WIDTH-1:0] cur_line;
  logic [ACC_WIDTH-1:0] cur_acc [5];
  logic                 cur_seg_begun;
  logic                 cur_halted;

  logic                    in_fire;
  b64vlq_pkg::ch_class_e   cls;
  logic [5:0]              digit;
  logic [ACC_WIDTH-1:0]    group;
  logic [ACC_WIDTH-1:0]    raw;
  logic [ACC_WIDTH-1:0]    mag;
  logic [ACC_WIDTH-1:0]    acc_sel;
  logic [ACC_WIDTH-1:0]    acc_new;
  logic                    res_push;
  b64vlq_pkg::res_t        res_d;
  b64vlq_pkg::res_t        res_o;

  // Check helpers
  logic                    rec_vals_zero;
  logic                    quote_fire;
  logic                    quote_state_ok;

  function automatic logic [31:0] to_out(input logic [ACC_WIDTH-1:0] v);
    logic [ACC_WIDTH+31:0] ext;
    ext = {32'b0, v};
    return ext[31:0];
  endfunction

  assign in_fire = in_valid_i && in_ready_o;

  // Clear-on-first view of the state
  always_comb begin
    cur_partial   = first_i ? '0 : partial_q;
    cur_shift     = first_i ? '0 : shift_q;
    cur_fcnt      = first_i ? '0 : fcnt_q;
    cur_line      = first_i ? '0 : line_q;
    cur_seg_begun = first_i ? 1'b0 : seg_begun_q;
    cur_halted    = first_i ? 1'b0 : halted_q;
    for (int k = 0; k < 5; k++) begin
      cur_acc[k] = first_i ? '0 : acc_q[k];
    end
    if (first_i) begin
      cur_acc[2] = ACC_ONE;
    end
  end

  // Digit decode and VLQ merge; groups land in disjoint bits
  assign cls     = b64vlq_pkg::classify(ch_i);
  assign digit   = b64vlq_pkg::b64_value(ch_i);
  assign group   = ACC_WIDTH'(digit[b64vlq_pkg::VLQ_GROUP_BITS-1:0]) << cur_shift;
  assign raw     = cur_partial | group;
  assign mag     = raw >> 1;
  assign acc_sel = cur_acc[cur_fcnt];
  assign acc_new = raw[0] ? (acc_sel - mag) : (acc_sel + mag);

  // Record built from the current accumulators
  function automatic b64vlq_pkg::res_t make_res(
    input logic                 seg,
    input logic                 err,
    input logic                 done,
    input logic [ACC_WIDTH-1:0] line,
    input logic [ACC_WIDTH-1:0] a0,
    input logic [ACC_WIDTH-1:0] a1,
    input logic [ACC_WIDTH-1:0] a2,
    input logic [ACC_WIDTH-1:0] a3,
    input logic [ACC_WIDTH-1:0] a4
  );
    b64vlq_pkg::res_t r;
    r.gen_line    = seg ? to_out(line) : '0;
    r.gen_column  = seg ? to_out(a0) : '0;
    r.src_idx     = seg ? to_out(a1) : '0;
    r.orig_line   = seg ? to_out(a2) : '0;
    r.orig_col    = seg ? to_out(a3) : '0;
    r.name_idx    = seg ? to_out(a4) : '0;
    r.has_segment = seg;
    r.error       = err;
    r.done_res    = done;
    return r;
  endfunction

  // Next state and record
  always_comb begin
    partial_d   = partial_q;
    shift_d     = shift_q;
    fcnt_d      = fcnt_q;
    line_d      = line_q;
    seg_begun_d = seg_begun_q;
    halted_d    = halted_q;
    for (int k = 0; k < 5; k++) begin
      acc_d[k] = acc_q[k];
    end
    res_push = 1'b0;
    res_d    = make_res(1'b0, 1'b0, 1'b0, cur_line, cur_acc[0], cur_acc[1],
                        cur_acc[2], cur_acc[3], cur_acc[4]);

    if (in_fire) begin
      partial_d   = cur_partial;
      shift_d     = cur_shift;
      fcnt_d      = cur_fcnt;
      line_d      = cur_line;
      seg_begun_d = cur_seg_begun;
      halted_d    = cur_halted;
      for (int k = 0; k < 5; k++) begin
        acc_d[k] = cur_acc[k];
      end

      if (!cur_halted) begin
        unique case (cls)
          b64vlq_pkg::CLS_COMMA, b64vlq_pkg::CLS_SEMI: begin
            res_push    = 1'b1;
            res_d       = make_res(1'b1, 1'b0, 1'b0, cur_line, cur_acc[0],
                                   cur_acc[1], cur_acc[2], cur_acc[3],
                                   cur_acc[4]);
            partial_d   = '0;
            shift_d     = '0;
            fcnt_d      = '0;
            seg_begun_d = 1'b0;
            if (cls == b64vlq_pkg::CLS_SEMI) begin
              acc_d[0] = '0;
              line_d   = cur_line + ACC_ONE;
            end
          end
          b64vlq_pkg::CLS_QUOTE: begin
            res_push    = 1'b1;
            res_d       = make_res(cur_seg_begun, 1'b0, 1'b1, cur_line,
                                   cur_acc[0], cur_acc[1], cur_acc[2],
                                   cur_acc[3], cur_acc[4]);
            partial_d   = '0;
            shift_d     = '0;
            fcnt_d      = '0;
            seg_begun_d = 1'b0;
            halted_d    = 1'b1;
          end
          b64vlq_pkg::CLS_DIGIT: begin
            if (cur_fcnt >= b64vlq_pkg::NUM_FIELDS) begin
              // sixth field in one segment
              res_push = 1'b1;
              res_d    = make_res(1'b0, 1'b1, 1'b1, cur_line, cur_acc[0],
                                  cur_acc[1], cur_acc[2], cur_acc[3],
                                  cur_acc[4]);
              halted_d = 1'b1;
            end else begin
              seg_begun_d = 1'b1;
              partial_d   = raw;
              if (cur_shift < b64vlq_pkg::VLQ_SHIFT_MAX) begin
                shift_d = cur_shift + b64vlq_pkg::VLQ_SHIFT_STEP;
              end
              // no continuation bit: number complete
              if (!digit[5]) begin
                acc_d[cur_fcnt] = acc_new;
                fcnt_d          = cur_fcnt + 3'd1;
                partial_d       = '0;
                shift_d         = '0;
              end
            end
          end
          default: begin
            res_push = 1'b1;
            res_d    = make_res(1'b0, 1'b1, 1'b1, cur_line, cur_acc[0],
                                cur_acc[1], cur_acc[2], cur_acc[3],
                                cur_acc[4]);
            halted_d = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q   <= '0;
      shift_q     <= '0;
      fcnt_q      <= '0;
      line_q      <= '0;
      seg_begun_q <= 1'b0;
      halted_q    <= 1'b0;
      for (int k = 0; k < 5; k++) begin
        acc_q[k] <= (k == 2) ? ACC_ONE : '0;
      end
    end else begin
      partial_q   <= partial_d;
      shift_q     <= shift_d;
      fcnt_q      <= fcnt_d;
      line_q      <= line_d;
      seg_begun_q <= seg_begun_d;
      halted_q    <= halted_d;
      for (int k = 0; k < 5; k++) begin
        acc_q[k] <= acc_d[k];
      end
    end
  end

  // Output buffer
  b64vlq_out_skid u_out_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .data_i      (res_d),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (res_o)
  );

  assign gen_line_o    = res_o.gen_line;
  assign gen_column_o  = res_o.gen_column;
  assign src_idx_o     = res_o.src_idx;
  assign orig_line_o   = res_o.orig_line;
  assign orig_col_o    = res_o.orig_col;
  assign name_idx_o    = res_o.name_idx;
  assign has_segment_o = res_o.has_segment;
  assign error_o       = res_o.error;
  assign done_res_o    = res_o.done_res;

  // Checks
  assign rec_vals_zero  = (gen_line_o == '0) && (gen_column_o == '0) &&
                          (src_idx_o == '0) && (orig_line_o == '0) &&
                          (orig_col_o == '0) && (name_idx_o == '0);
  assign quote_fire     = in_fire && !cur_halted && (cls == b64vlq_pkg::CLS_QUOTE);
  assign quote_state_ok = halted_q && (fcnt_q == '0) && !seg_begun_q;

  `B64VLQ_ASSERT_IMP(a_empty_rec_zero, clk_i, rst_ni, out_valid_o && !has_segment_o, rec_vals_zero, "record without segment carries values")
  `B64VLQ_ASSERT_IMP(a_err_is_final, clk_i, rst_ni, out_valid_o && error_o, done_res_o && !has_segment_o, "error record not final")
  `B64VLQ_ASSERT_NXT(a_quote_halts, clk_i, rst_ni, quote_fire, quote_state_ok, "closing quote did not halt")

endmodule

// File: dv/base64_vlq_mapping_decoder_unit_tb.sv
`timescale 1ns / 100ps

module base64_vlq_mapping_decoder_unit_tb;

  localparam int DIR_ROWS     = 26;
  localparam int RAND_ITEMS   = 1350;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_LEN     = 400;

  typedef b64vlq_pkg::res_t res_t;

  // Directed rows either carry a typed-in record or defer to the predictor
  typedef enum logic {ROW_PREDICT, ROW_TYPED} row_kind_e;

  typedef struct {
    logic [7:0] ch;
    logic       first;
    row_kind_e  kind;
    res_t       res;
  } dir_row_t;

  typedef struct {
    logic [7:0] ch;
    logic       first;
    bit         pause;
    row_kind_e  kind;
    res_t       res;
  } char_item_t;

  // Running decode state of the predictor
  typedef struct {
    logic [31:0] partial;
    int unsigned shift;
    int unsigned nfield;
    logic [31:0] line;
    logic [31:0] col;
    logic [31:0] src;
    logic [31:0] oline;
    logic [31:0] ocol;
    logic [31:0] name;
    bit          begun;
    bit          halted;
  } dec_state_t;

  localparam res_t RES_DONE_ONLY = '{done_res: 1'b1, default: '0};
  localparam res_t RES_ERROR     = '{error: 1'b1, done_res: 1'b1, default: '0};
  localparam res_t RES_EMPTY_SEG = '{orig_line: 32'd1, has_segment: 1'b1, default: '0};

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  ch_i        = 8'h00;
  logic        first_i     = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] gen_line_o;
  logic [31:0] gen_column_o;
  logic [31:0] src_idx_o;
  logic [31:0] orig_line_o;
  logic [31:0] orig_col_o;
  logic [31:0] name_idx_o;
  logic        has_segment_o;
  logic        error_o;
  logic        done_res_o;

  base64_vlq_mapping_decoder_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .ch_i          (ch_i),
    .first_i       (first_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .gen_line_o    (gen_line_o),
    .gen_column_o  (gen_column_o),
    .src_idx_o     (src_idx_o),
    .orig_line_o   (orig_line_o),
    .orig_col_o    (orig_col_o),
    .name_idx_o    (name_idx_o),
    .has_segment_o (has_segment_o),
    .error_o       (error_o),
    .done_res_o    (done_res_o)
  );

  dec_state_t dec;
  res_t       record_q[$];
  char_item_t char_q[$];
  dir_row_t   dir_tbl[DIR_ROWS];

  int  fail_cnt   = 0;
  int  cycle_cnt  = 0;
  int  in_acc     = 0;
  int  rec_cnt    = 0;
  int  seg_cnt    = 0;
  int  errrec_cnt = 0;
  int  str_cnt    = 0;
  int  gen_count  = 0;
  bit  gen_first  = 1'b0;
  bit  pause_next = 1'b0;
  bit  mid_pause  = 1'b0;

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    fail_cnt++;
    $display("mismatch at cycle %0d: %s", cycle_cnt, what);
  endtask

  task automatic check_field(input string fname, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("record %0d %s got %h want %h", rec_cnt, fname, got, want));
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic int digit_of(input logic [7:0] c);
    int v;
    v = -1;
    if (c >= b64vlq_pkg::CH_UP_A && c <= b64vlq_pkg::CH_UP_Z)
      v = int'(c - b64vlq_pkg::CH_UP_A);
    else if (c >= b64vlq_pkg::CH_LO_A && c <= b64vlq_pkg::CH_LO_Z)
      v = int'(c - b64vlq_pkg::CH_LO_A) + 26;
    else if (c >= b64vlq_pkg::CH_DIG_0 && c <= b64vlq_pkg::CH_DIG_9)
      v = int'(c - b64vlq_pkg::CH_DIG_0) + 52;
    else if (c == b64vlq_pkg::CH_PLUS)
      v = 62;
    else if (c == b64vlq_pkg::CH_SLASH)
      v = 63;
    return v;
  endfunction

  function automatic void reset_decoder();
    dec.partial = '0;
    dec.shift   = 0;
    dec.nfield  = 0;
    dec.line    = '0;
    dec.col     = '0;
    dec.src     = '0;
    dec.oline   = 32'd1;
    dec.ocol    = '0;
    dec.name    = '0;
    dec.begun   = 1'b0;
    dec.halted  = 1'b0;
  endfunction

  function automatic void close_segment();
    dec.partial = '0;
    dec.shift   = 0;
    dec.nfield  = 0;
    dec.begun   = 1'b0;
  endfunction

  function automatic res_t make_rec(input bit seg, input bit err, input bit done);
    res_t r;
    r = '0;
    if (seg) begin
      r.gen_line    = dec.line;
      r.gen_column  = dec.col;
      r.src_idx     = dec.src;
      r.orig_line   = dec.oline;
      r.orig_col    = dec.ocol;
      r.name_idx    = dec.name;
      r.has_segment = 1'b1;
    end
    r.error    = err;
    r.done_res = done;
    return r;
  endfunction

  // Applies one character; returns 1 when it yields a record
  function automatic bit predict_char(input logic [7:0] c, input logic first,
                                      output res_t rec);
    int          d;
    logic [31:0] mag;
    logic [31:0] delta;
    rec = '0;
    if (first) reset_decoder();
    if (dec.halted) return 1'b0;

    if (c == b64vlq_pkg::CH_COMMA || c == b64vlq_pkg::CH_SEMI) begin
      rec = make_rec(1'b1, 1'b0, 1'b0);
      close_segment();
      if (c == b64vlq_pkg::CH_SEMI) begin
        dec.col  = '0;
        dec.line = dec.line + 32'd1;
      end
      return 1'b1;
    end
    if (c == b64vlq_pkg::CH_QUOTE) begin
      rec = make_rec(dec.begun, 1'b0, 1'b1);
      close_segment();
      dec.halted = 1'b1;
      return 1'b1;
    end

    d = digit_of(c);
    if (d < 0 || dec.nfield >= b64vlq_pkg::NUM_FIELDS) begin
      rec = make_rec(1'b0, 1'b1, 1'b1);
      dec.halted = 1'b1;
      return 1'b1;
    end

    // Merge the 5-bit group; groups past the accumulator width are dropped
    dec.begun = 1'b1;
    if (dec.shift < b64vlq_pkg::ACC_WIDTH_DEF)
      dec.partial = dec.partial + (32'(d & 31) << dec.shift);
    if (dec.shift < b64vlq_pkg::VLQ_SHIFT_MAX) dec.shift += b64vlq_pkg::VLQ_SHIFT_STEP;

    // Last digit of the number: sign-magnitude delta into the next field
    if ((d & 32) == 0) begin
      mag   = dec.partial >> 1;
      delta = dec.partial[0] ? (32'd0 - mag) : mag;
      case (dec.nfield)
        0:       dec.col   = dec.col + delta;
        1:       dec.src   = dec.src + delta;
        2:       dec.oline = dec.oline + delta;
        3:       dec.ocol  = dec.ocol + delta;
        default: dec.name  = dec.name + delta;
      endcase
      dec.nfield++;
      dec.partial = '0;
      dec.shift   = 0;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] enc_digit(input logic [5:0] v);
    logic [7:0] c;
    if (v < 26)       c = b64vlq_pkg::CH_UP_A + 8'(v);
    else if (v < 52)  c = b64vlq_pkg::CH_LO_A + 8'(v - 26);
    else if (v < 62)  c = b64vlq_pkg::CH_DIG_0 + 8'(v - 52);
    else if (v == 62) c = b64vlq_pkg::CH_PLUS;
    else              c = b64vlq_pkg::CH_SLASH;
    return c;
  endfunction

  task automatic emit(input logic [7:0] c, input bit counted);
    char_item_t it;
    it.ch    = c;
    it.first = gen_first;
    it.pause = pause_next;
    it.kind  = ROW_PREDICT;
    it.res   = '0;
    char_q.push_back(it);
    gen_first  = 1'b0;
    pause_next = 1'b0;
    if (counted) gen_count++;
  endtask

  // Characters after a halt are ignored by the block
  task automatic add_junk();
    int n;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) emit(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // One mapping string: mostly well formed, with some noise and broken tails
  task automatic gen_string();
    int         nseg;
    int         nf;
    int         ndig;
    int         roll;
    logic [7:0] c;
    logic       cont;
    bit         is_sep;
    int         nf_pick[10];
    nf_pick = '{1, 4, 4, 5, 5, 5, 1, 4, 2, 3};
    gen_first = 1'b1;
    str_cnt++;
    if (!mid_pause && gen_count >= 700) begin
      pause_next = 1'b1;
      mid_pause  = 1'b1;
    end

    // Occasional non-digit noise as the first character
    if ($urandom_range(0, 19) == 0) begin
      c = 8'($urandom_range(0, 255));
      if (digit_of(c) < 0) begin
        emit(c, 1'b1);
        if (c != b64vlq_pkg::CH_COMMA && c != b64vlq_pkg::CH_SEMI) begin
          add_junk();
          return;
        end
      end
    end

    nseg = $urandom_range(0, 8);
    for (int s = 0; s < nseg; s++) begin
      roll = $urandom_range(0, 99);
      nf   = (roll < 6) ? 0 : nf_pick[$urandom_range(0, 9)];
      for (int f = 0; f < nf; f++) begin
        roll = $urandom_range(0, 99);
        if (roll < 60)      ndig = $urandom_range(1, 2);
        else if (roll < 92) ndig = $urandom_range(3, 7);
        else                ndig = $urandom_range(8, 14);
        for (int k = 0; k < ndig; k++) begin
          cont = (k < ndig - 1);
          emit(enc_digit({cont, 5'($urandom_range(0, 31))}), 1'b1);
        end
      end
      // sixth field
      if (nf == 5 && $urandom_range(0, 99) < 3) begin
        emit(enc_digit(6'($urandom_range(0, 63))), 1'b1);
        add_junk();
        return;
      end
      // number cut off by the separator
      if (nf < 5 && $urandom_range(0, 99) < 8)
        emit(enc_digit({1'b1, 5'($urandom_range(0, 31))}), 1'b1);
      // random byte ahead of the separator
      if ($urandom_range(0, 99) < 3) begin
        c = 8'($urandom_range(0, 255));
        emit(c, 1'b1);
        is_sep = (c == b64vlq_pkg::CH_COMMA) || (c == b64vlq_pkg::CH_SEMI);
        if (c == b64vlq_pkg::CH_QUOTE || (digit_of(c) < 0 && !is_sep) ||
            (digit_of(c) >= 0 && nf >= 5)) begin
          add_junk();
          return;
        end
      end
      emit(($urandom_range(0, 9) < 3) ? b64vlq_pkg::CH_SEMI : b64vlq_pkg::CH_COMMA, 1'b1);
    end

    // Closing quote, or the string is abandoned by the next first
    if ($urandom_range(0, 99) < 85) begin
      emit(b64vlq_pkg::CH_QUOTE, 1'b1);
      add_junk();
    end
  endtask

  // ---------------------------------------------------------------- monitor

  // Predict on each accepted item, then check each accepted record
  always @(posedge clk_i) begin : monitor
    res_t       pred;
    res_t       got;
    res_t       want;
    char_item_t it;
    bit         has;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        it  = char_q[in_acc];
        has = predict_char(ch_i, first_i, pred);
        if (it.kind == ROW_TYPED) record_q.push_back(it.res);
        else if (has) record_q.push_back(pred);
        in_acc++;
      end
      if (out_valid_o && out_ready_i) begin
        got = '{gen_line_o, gen_column_o, src_idx_o, orig_line_o,
                orig_col_o, name_idx_o, has_segment_o, error_o, done_res_o};
        if (got.has_segment) seg_cnt++;
        if (got.error) errrec_cnt++;
        if (record_q.size() == 0) begin
          report_mismatch($sformatf("record %0d arrived with nothing expected", rec_cnt));
        end else begin
          want = record_q.pop_front();
          check_field("gen_line", got.gen_line, want.gen_line);
          check_field("gen_column", got.gen_column, want.gen_column);
          check_field("src_idx", got.src_idx, want.src_idx);
          check_field("orig_line", got.orig_line, want.orig_line);
          check_field("orig_col", got.orig_col, want.orig_col);
          check_field("name_idx", got.name_idx, want.name_idx);
          check_field("has_segment", 32'(got.has_segment), 32'(want.has_segment));
          check_field("error", 32'(got.error), 32'(want.error));
          check_field("done_res", 32'(got.done_res), 32'(want.done_res));
        end
        rec_cnt++;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // Stall pattern in modes of random length, plus two long hold-offs
  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    int holds_done;
    mode       = 0;
    mode_left  = 0;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (holds_done < 2 && in_acc >= 300 + 700 * holds_done) begin
        holds_done++;
        hold_left = HOLD_LEN;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(0, 1) == 0);
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- main

  initial begin : main
    char_item_t it;
    int         burst_left;
    int         gap;

    // Directed table
    dir_tbl = '{
      '{b64vlq_pkg::CH_QUOTE, 1'b1, ROW_TYPED,   RES_DONE_ONLY},  // empty string
      '{"A",                  1'b0, ROW_PREDICT, '0},             // halted, ignored
      '{b64vlq_pkg::CH_COMMA, 1'b1, ROW_TYPED,   RES_EMPTY_SEG},  // empty segment
      '{"C",                  1'b0, ROW_PREDICT, '0},             // +1
      '{"D",                  1'b0, ROW_PREDICT, '0},             // -1
      '{"E",                  1'b0, ROW_PREDICT, '0},
      '{"F",                  1'b0, ROW_PREDICT, '0},
      '{"/",                  1'b0, ROW_PREDICT, '0},             // three-digit name delta
      '{"9",                  1'b0, ROW_PREDICT, '0},
      '{"Z",                  1'b0, ROW_PREDICT, '0},
      '{b64vlq_pkg::CH_SEMI,  1'b0, ROW_PREDICT, '0},
      '{"A",                  1'b0, ROW_PREDICT, '0},
      '{"A",                  1'b0, ROW_PREDICT, '0},
      '{"A",                  1'b0, ROW_PREDICT, '0},
      '{"A",                  1'b0, ROW_PREDICT, '0},
      '{"A",                  1'b0, ROW_PREDICT, '0},
      '{"A",                  1'b0, ROW_TYPED,   RES_ERROR},      // sixth field
      '{"z",                  1'b0, ROW_PREDICT, '0},             // halted, ignored
      '{8'hFF,                1'b1, ROW_TYPED,   RES_ERROR},      // invalid byte
      '{8'h00,                1'b1, ROW_TYPED,   RES_ERROR},
      '{"a",                  1'b1, ROW_PREDICT, '0},
      '{"+",                  1'b0, ROW_PREDICT, '0},             // cut off by separator
      '{b64vlq_pkg::CH_SEMI,  1'b0, ROW_PREDICT, '0},
      '{b64vlq_pkg::CH_QUOTE, 1'b0, ROW_TYPED,   RES_DONE_ONLY},  // quote after separator
      '{"g",                  1'b1, ROW_PREDICT, '0},
      '{b64vlq_pkg::CH_QUOTE, 1'b0, ROW_PREDICT, '0}              // quote cuts open number
    };
    foreach (dir_tbl[i]) begin
      it.ch    = dir_tbl[i].ch;
      it.first = dir_tbl[i].first;
      it.pause = 1'b0;
      it.kind  = dir_tbl[i].kind;
      it.res   = dir_tbl[i].res;
      char_q.push_back(it);
    end

    // Random strings; wait for the directed records first
    pause_next = 1'b1;
    while (gen_count < RAND_ITEMS) gen_string();

    reset_decoder();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender: bursts of random length with random gaps
    burst_left = 0;
    foreach (char_q[i]) begin
      if (char_q[i].pause) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (record_q.size() != 0) @(posedge clk_i);
        repeat (DRAIN_CYCLES) @(posedge clk_i);
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 :
              ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      if (burst_left > 0) burst_left--;
      in_valid_i <= 1'b1;
      ch_i       <= char_q[i].ch;
      first_i    <= char_q[i].first;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
    end
    in_valid_i <= 1'b0;

    // Drain
    while (record_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d characters: a directed table and %0d random strings",
             in_acc, str_cnt);
    $display("%0d records checked, %0d with segments, %0d error records, two long stalls",
             rec_cnt, seg_cnt, errrec_cnt);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
